// ===== rtl/cqd_pkg.sv =====
// shared types and codes for the circular queue with dump
package cqd_pkg;

    localparam int FIELD_W = 32;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [FIELD_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [FIELD_W-1:0] data_out;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] value;
    } cqd_cmd_t;

endpackage

// ===== rtl/circular_queue_with_dump.sv =====
// top level of the circular queue with dump
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  in_item_t  (command, push_value)
//   res      out        res_valid/res_stall  out_item_t (status, data_out, last)
//
// push, overflow and underflow results show in the cycle after the back end
// takes them; a pop passes the registered read port of the storage, then the
// result register; a dump of n entries reads one per cycle unless res_stall holds.
// a two-entry command queue lets requests arrive while the back end works.
// reset clears pointers, occupancy and control state only; storage needs no clearing pass.
// res_stall holds the result register and the back end; req_stall rises when
// the command queue is full.
module circular_queue_with_dump
    import cqd_pkg::*;
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res
);

    logic     cmd_valid;
    cqd_cmd_t cmd;
    logic     cmd_take;

    cqd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    cqd_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/cqd_front.sv =====
// front end: takes requests, drops unused codes, holds a two-entry command queue
module cqd_front
    import cqd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      cmd_valid,
    output cqd_cmd_t  cmd,
    input  logic      cmd_take
);

    cqd_cmd_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       known;
    logic       enq;
    logic       deq;

    assign req_stall = (count_reg == 2'd2);
    assign accept    = req_valid && !req_stall;
    assign known     = (req.command == CMD_PUSH) || (req.command == CMD_POP)
                    || (req.command == CMD_DUMP);
    // unused command codes are taken and dropped here
    assign enq       = accept && known;

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign deq       = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (deq)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg].op    <= req.command;
            q_reg[wr_ptr_reg].value <= req.push_value;
        end
    end

endmodule

// ===== rtl/cqd_back.sv =====
// back end: ring storage, pointers, occupancy and the result register
module cqd_back
    import cqd_pkg::*;
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cqd_cmd_t  cmd,
    output logic      cmd_take,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic [STORE_W-1:0] mem [DEPTH];

    logic               state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]   left_reg, left_next;
    logic               pend_reg, pend_next;
    logic               rd_last_reg, rd_last_next;
    logic [STORE_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic               out_free;
    logic               full;
    logic               empty;
    logic               wr_en;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               consume;
    logic               load;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || !res_stall;
    assign full      = (occ_reg == OCC_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign consume   = pend_reg && out_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        rd_ptr_next  = rd_ptr_reg;
        left_next    = left_reg;
        pend_next    = pend_reg;
        rd_last_next = rd_last_reg;
        cmd_take     = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = rd_ptr_reg;
        load         = 1'b0;
        out_next     = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_PUSH:
                        begin
                            if (out_free)
                            begin
                                cmd_take          = 1'b1;
                                load              = 1'b1;
                                out_next.data_out = '0;
                                out_next.last     = 1'b1;
                                if (full)
                                begin
                                    out_next.status = ST_OVERFLOW;
                                end
                                else
                                begin
                                    out_next.status = ST_OK;
                                    wr_en           = 1'b1;
                                    tail_next       = wrap_inc(tail_reg);
                                    occ_next        = occ_reg + OCC_W'(1);
                                end
                            end
                        end
                        CMD_POP, CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                if (out_free)
                                begin
                                    cmd_take          = 1'b1;
                                    load              = 1'b1;
                                    out_next.status   = ST_UNDERFLOW;
                                    out_next.data_out = '0;
                                    out_next.last     = 1'b1;
                                end
                            end
                            else
                            begin
                                // first read goes out now, the result follows from the run state
                                cmd_take    = 1'b1;
                                rd_en       = 1'b1;
                                rd_addr     = head_reg;
                                pend_next   = 1'b1;
                                rd_ptr_next = wrap_inc(head_reg);
                                state_next  = S_RUN;
                                if (cmd.op == CMD_POP)
                                begin
                                    rd_last_next = 1'b1;
                                    left_next    = '0;
                                    head_next    = wrap_inc(head_reg);
                                    occ_next     = occ_reg - OCC_W'(1);
                                end
                                else
                                begin
                                    rd_last_next = (occ_reg == OCC_W'(1));
                                    left_next    = occ_reg - OCC_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (consume)
                begin
                    load              = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.data_out = FIELD_W'(rd_data_reg);
                    out_next.last     = rd_last_reg;
                end
                // next read overlaps the hand-off of the current word
                if ((left_reg != '0) && (!pend_reg || consume))
                begin
                    rd_en        = 1'b1;
                    rd_addr      = rd_ptr_reg;
                    pend_next    = 1'b1;
                    rd_last_next = (left_reg == OCC_W'(1));
                    left_next    = left_reg - OCC_W'(1);
                    rd_ptr_next  = wrap_inc(rd_ptr_reg);
                end
                else if (consume)
                begin
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            rd_ptr_reg    <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            rd_ptr_reg    <= rd_ptr_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= cmd.value[STORE_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
